### src/eapf_pkg.sv
// ----------------------------------------------------------------------------
// eapf_pkg
// Shared types and constants of the escape-aware pattern finder.
// ----------------------------------------------------------------------------
package eapf_pkg;

	// Escape character of the text.
	localparam logic [7:0] BACKSLASH = 8'h5C;

	// Hard limit on the pattern length carried by the pattern register.
	localparam int PATTERN_LIMIT = 8;

	// Configuration register indexes.
	localparam logic CFG_PATTERN_BYTES  = 1'b0;
	localparam logic CFG_PATTERN_LENGTH = 1'b1;

	// One result item.
	typedef struct packed {
		logic        match_found;
		logic [15:0] match_start;
		logic        text_end;
		logic        offset_overflow;
	} result_t;

endpackage

### src/eapf_step.sv
// ----------------------------------------------------------------------------
// eapf_step
// Next-state and result logic for one text byte: window shift, escape
// tracking, offset counting and the parallel pattern compare.
// ----------------------------------------------------------------------------
module eapf_step #(
	parameter int LEN_LIMIT   = 8,
	parameter int OFFSET_BITS = 16,
	parameter int SEEN_W      = 4,
	parameter int IDX_W       = 3
) (
	input  logic [7:0]             text_byte,
	input  logic                   last_byte,
	input  logic [63:0]            pattern_bytes,
	input  logic [3:0]             pattern_length,
	input  logic [7:0]             win      [LEN_LIMIT],
	input  logic                   esc      [LEN_LIMIT],
	input  logic                   run_odd,
	input  logic [OFFSET_BITS-1:0] offset,
	input  logic [OFFSET_BITS:0]   next_start,
	input  logic [SEEN_W-1:0]      seen,
	input  logic                   ovf,
	output logic [7:0]             win_nxt  [LEN_LIMIT],
	output logic                   esc_nxt  [LEN_LIMIT],
	output logic                   run_odd_nxt,
	output logic [OFFSET_BITS-1:0] offset_nxt,
	output logic [OFFSET_BITS:0]   next_start_nxt,
	output logic [SEEN_W-1:0]      seen_nxt,
	output logic                   ovf_nxt,
	output eapf_pkg::result_t      result
);

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

	logic [7:0]             win_sh [LEN_LIMIT];
	logic                   esc_sh [LEN_LIMIT];
	logic [OFFSET_BITS-1:0] cur;
	logic [OFFSET_BITS:0]   nas;
	logic                   ovf_cur;
	logic [4:0]             fill;
	logic [3:0]             len;
	logic [3:0]             len_m1;
	logic [3:0]             idx;
	logic [OFFSET_BITS-1:0] start;
	logic                   found;
	logic                   bytes_eq;

	// Shift the new byte and its escape mark into the window.
	always_comb begin
		win_sh[0] = text_byte;
		esc_sh[0] = run_odd;
		for (int i = 1; i < LEN_LIMIT; i++) begin
			win_sh[i] = win[i-1];
			esc_sh[i] = esc[i-1];
		end
	end

	// Offset of this byte, with saturation and the matching shift of the
	// non-overlap bound so that it keeps its true distance.
	always_comb begin
		nas     = next_start;
		ovf_cur = ovf;
		if (seen == '0) begin
			cur = '0;
		end else if (offset == OFFSET_MAX) begin
			cur     = OFFSET_MAX;
			ovf_cur = 1'b1;
			if (next_start != '0) begin
				nas = next_start - 1'b1;
			end
		end else begin
			cur = offset + 1'b1;
		end
	end

	// Effective length, clipped to the window.
	assign len    = (pattern_length > 4'(LEN_LIMIT)) ? 4'(LEN_LIMIT) : pattern_length;
	assign len_m1 = len - 4'd1;
	assign fill   = 5'(seen) + 5'd1;
	assign start  = cur - OFFSET_BITS'(len_m1);

	// Parallel compare of the window against the pattern.
	always_comb begin
		bytes_eq = 1'b1;
		idx      = '0;
		for (int j = 0; j < LEN_LIMIT; j++) begin
			if (4'(j) < len) begin
				idx = len_m1 - 4'(j);
				if (win_sh[idx[IDX_W-1:0]] != pattern_bytes[8*j +: 8]) begin
					bytes_eq = 1'b0;
				end
			end
		end
	end

	assign found = (len != 4'd0) && (fill >= {1'b0, len}) &&
		({1'b0, start} >= nas) && !esc_sh[len_m1[IDX_W-1:0]] && bytes_eq;

	// Result of this byte.
	always_comb begin
		result.match_found     = found;
		result.match_start     = found ? 16'(start) : 16'd0;
		result.text_end        = last_byte;
		result.offset_overflow = ovf_cur;
	end

	// Next text state; the last byte of a text clears everything.
	always_comb begin
		if (last_byte) begin
			for (int i = 0; i < LEN_LIMIT; i++) begin
				win_nxt[i] = 8'd0;
				esc_nxt[i] = 1'b0;
			end
			run_odd_nxt    = 1'b0;
			offset_nxt     = '0;
			next_start_nxt = '0;
			seen_nxt       = '0;
			ovf_nxt        = 1'b0;
		end else begin
			win_nxt        = win_sh;
			esc_nxt        = esc_sh;
			run_odd_nxt    = (text_byte == eapf_pkg::BACKSLASH) ? !run_odd : 1'b0;
			offset_nxt     = cur;
			next_start_nxt = found ? ({1'b0, cur} + 1'b1) : nas;
			seen_nxt       = (fill > 5'(LEN_LIMIT)) ? SEEN_W'(LEN_LIMIT) : fill[SEEN_W-1:0];
			ovf_nxt        = ovf_cur;
		end
	end

endmodule

### src/escape_aware_pattern_finder.sv
// ----------------------------------------------------------------------------
// escape_aware_pattern_finder
// Streams a text one byte per item and reports each leftmost, non-overlapping
// match of a configured pattern whose first byte is not escaped.
// ----------------------------------------------------------------------------
// Pipeline: a byte accepted sits in the input register, and its result moves
// into the result register and shows on m_tvalid once that register is free.
// Throughput: one byte per cycle while results are taken; the window compare
// and offset update are combinational between the input and result registers.
// Reset: arst_n clears the text state, the pattern to zero and the length
// to one; no clearing pass is needed, the block is ready right after reset.
module escape_aware_pattern_finder #(
	parameter int MAX_PATTERN = 8,
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata,
	// Text input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // last_byte
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] match_start
	output logic [1:0]  m_tuser,   // [0] match_found, [1] offset_overflow
	output logic        m_tlast    // text_end
);

	localparam int LEN_LIMIT = (MAX_PATTERN < eapf_pkg::PATTERN_LIMIT) ?
		MAX_PATTERN : eapf_pkg::PATTERN_LIMIT;
	localparam int SEEN_W = $clog2(LEN_LIMIT + 1);
	localparam int IDX_W  = (LEN_LIMIT > 1) ? $clog2(LEN_LIMIT) : 1;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

	logic [63:0]            pattern_q;
	logic [3:0]             length_q;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;

	logic [7:0]             win_q  [LEN_LIMIT];
	logic                   esc_q  [LEN_LIMIT];
	logic                   odd_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [OFFSET_BITS:0]   nas_q;
	logic [SEEN_W-1:0]      seen_q;
	logic                   ovf_q;

	logic [7:0]             win_d  [LEN_LIMIT];
	logic                   esc_d  [LEN_LIMIT];
	logic                   odd_d;
	logic [OFFSET_BITS-1:0] off_d;
	logic [OFFSET_BITS:0]   nas_d;
	logic [SEEN_W-1:0]      seen_d;
	logic                   ovf_d;
	eapf_pkg::result_t      res_d;

	logic                   out_v_q;
	eapf_pkg::result_t      out_q;

	logic                   advance;
	logic                   fire_s1;

	// Handshake: the result register frees when empty or being taken.
	assign advance  = !out_v_q || m_tready;
	assign fire_s1  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eapf_pkg::CFG_PATTERN_BYTES:  pattern_q <= cfg_wdata;
				eapf_pkg::CFG_PATTERN_LENGTH: length_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Per-byte logic.
	eapf_step #(
		.LEN_LIMIT   (LEN_LIMIT),
		.OFFSET_BITS (OFFSET_BITS),
		.SEEN_W      (SEEN_W),
		.IDX_W       (IDX_W)
	) u_step (
		.text_byte      (byte_s1),
		.last_byte      (last_s1),
		.pattern_bytes  (pattern_q),
		.pattern_length (length_q),
		.win            (win_q),
		.esc            (esc_q),
		.run_odd        (odd_q),
		.offset         (off_q),
		.next_start     (nas_q),
		.seen           (seen_q),
		.ovf            (ovf_q),
		.win_nxt        (win_d),
		.esc_nxt        (esc_d),
		.run_odd_nxt    (odd_d),
		.offset_nxt     (off_d),
		.next_start_nxt (nas_d),
		.seen_nxt       (seen_d),
		.ovf_nxt        (ovf_d),
		.result         (res_d)
	);

	// Text state, updated as each byte moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEN_LIMIT; i++) begin
				win_q[i] <= 8'd0;
				esc_q[i] <= 1'b0;
			end
			odd_q  <= 1'b0;
			off_q  <= '0;
			nas_q  <= '0;
			seen_q <= '0;
			ovf_q  <= 1'b0;
		end else if (fire_s1) begin
			win_q  <= win_d;
			esc_q  <= esc_d;
			odd_q  <= odd_d;
			off_q  <= off_d;
			nas_q  <= nas_d;
			seen_q <= seen_d;
			ovf_q  <= ovf_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= res_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.match_start;
	assign m_tuser  = {out_q.offset_overflow, out_q.match_found};
	assign m_tlast  = out_q.text_end;

	// A last byte leaves the text state cleared.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && last_s1 |=> seen_q == '0 && off_q == '0 && !ovf_q && nas_q == '0)
		else $error("text state not cleared after last byte");

	// Any byte that is not last leaves at least one byte counted.
	a_seen_counts: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !last_s1 |=> seen_q != '0)
		else $error("byte count did not advance");

	// The overflow flag is only kept while the offset is saturated.
	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> off_q == OFFSET_MAX)
		else $error("overflow flag without saturated offset");

	// A result without a match carries a zero start.
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_q.match_found |-> out_q.match_start == 16'd0)
		else $error("nonzero start without a match");

	// After a match on a byte that is not last, the next allowed start sits one
	// past the end of that match.
	a_nas_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && res_d.match_found && !last_s1 |=> nas_q == {1'b0, off_q} + 1'b1)
		else $error("non-overlap bound not set after match");

endmodule

### sim/escape_aware_pattern_finder_tb.sv
// ----------------------------------------------------------------------------
// escape_aware_pattern_finder_tb
// Self-checking bench for the escape-aware pattern finder. Text bytes are
// streamed in with random bursts and gaps while the result side stalls on
// its own pattern. A behavioral copy of the finder predicts one result per
// accepted byte, and every result is checked in order against it. The run
// covers directed escape and overlap cases, many pattern settings and long
// result-side hold-offs.
// ----------------------------------------------------------------------------
module escape_aware_pattern_finder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     MAX_PATTERN = 8;
	localparam int     OFFSET_BITS = 16;
	localparam longint OFFSET_MAX  = (64'd1 << OFFSET_BITS) - 1;
	localparam int     LONG_HOLD   = 300;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [7:0] text_byte;
		logic       last_byte;
	} text_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = eapf_pkg::CFG_PATTERN_BYTES;
	logic [63:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;   // [15:0] match_start
	logic [1:0]  m_tuser;   // [0] match_found, [1] offset_overflow
	logic        m_tlast;   // text_end

	escape_aware_pattern_finder #(
		.MAX_PATTERN(MAX_PATTERN),
		.OFFSET_BITS(OFFSET_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Bytes waiting to be offered and results owed by the finder.
	text_item_t          text_queue[$];
	eapf_pkg::result_t   results_due[$];

	// Shadow of the pattern registers.
	logic [63:0] shadow_pattern = '0;
	logic [3:0]  shadow_length = 4'd1;

	// Shadow of the per-text scan state.
	logic [7:0] win_bytes[MAX_PATTERN];
	logic       win_escaped[MAX_PATTERN];
	logic       bs_run_odd = 1'b0;
	longint     cur_offset = 0;
	longint     next_start = 0;
	int         fill_count = 0;
	logic       sat_seen = 1'b0;

	int     mismatches = 0;
	longint cycle_count = 0;
	int     phase_items = 0;
	int     hold_requests = 0;
	int     hold_served = 0;
	int     hold_left = 0;
	int     gap_left = 0;
	int     burst_left = 0;
	int     rx_count = 0;
	int     ready_pct = 100;
	logic   in_taken = 1'b0;
	text_item_t next_item;

	initial begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			win_bytes[k] = '0;
			win_escaped[k] = 1'b0;
		end
	end

	initial begin
		forever #6 clk = ~clk;
	end

	// Advance the shadow finder by one byte and work out its result.
	task automatic scan_byte(input logic [7:0] b, input logic last,
		output eapf_pkg::result_t r);
		int     i;
		int     len;
		int     fill;
		longint cur;
		longint start;
		logic   hit;
		for (i = MAX_PATTERN - 1; i > 0; i--) begin
			win_bytes[i] = win_bytes[i - 1];
			win_escaped[i] = win_escaped[i - 1];
		end
		win_bytes[0] = b;
		win_escaped[0] = bs_run_odd;
		bs_run_odd = (b == eapf_pkg::BACKSLASH) ? ~bs_run_odd : 1'b0;

		// Offsets saturate, but the non-overlap limit keeps its true distance.
		if (fill_count == 0) begin
			cur = 0;
		end else if (cur_offset >= OFFSET_MAX) begin
			sat_seen = 1'b1;
			cur = OFFSET_MAX;
			if (next_start > 0)
				next_start--;
		end else begin
			cur = cur_offset + 1;
		end
		cur_offset = cur;
		fill = fill_count + 1;
		fill_count = (fill > eapf_pkg::PATTERN_LIMIT) ? eapf_pkg::PATTERN_LIMIT : fill;

		len = (shadow_length > eapf_pkg::PATTERN_LIMIT) ? eapf_pkg::PATTERN_LIMIT :
			int'(shadow_length);
		hit = 1'b0;
		start = 0;
		if (len >= 1 && fill >= len) begin
			start = cur - (len - 1);
			if (start >= next_start && !win_escaped[len - 1]) begin
				hit = 1'b1;
				for (i = 0; i < len; i++) begin
					if (win_bytes[len - 1 - i] != shadow_pattern[8 * i +: 8])
						hit = 1'b0;
				end
				if (hit)
					next_start = cur + 1;
			end
		end

		r.match_found = hit;
		r.match_start = hit ? start[15:0] : 16'd0;
		r.text_end = last;
		r.offset_overflow = sat_seen;

		// A last byte closes the text and clears all scan state.
		if (last) begin
			for (i = 0; i < MAX_PATTERN; i++) begin
				win_bytes[i] = '0;
				win_escaped[i] = 1'b0;
			end
			bs_run_odd = 1'b0;
			cur_offset = 0;
			next_start = 0;
			fill_count = 0;
			sat_seen = 1'b0;
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		text_item_t it;
		it.text_byte = b;
		it.last_byte = last;
		text_queue.push_back(it);
		phase_items++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], i == s.len() - 1);
	endtask

	// Build one text of at least target bytes, rich in pattern copies,
	// backslash runs and pattern fragments, then queue it.
	task automatic queue_random_text(input longint target);
		logic [7:0] text[$];
		int         elen;
		int         n;
		int         i;
		elen = (shadow_length > eapf_pkg::PATTERN_LIMIT) ? eapf_pkg::PATTERN_LIMIT :
			int'(shadow_length);
		if (elen == 0)
			elen = 1;
		while (text.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = $urandom_range(0, 2);
					for (i = 0; i < n; i++)
						text.push_back(eapf_pkg::BACKSLASH);
					for (i = 0; i < elen; i++)
						text.push_back(shadow_pattern[8 * i +: 8]);
				end
				3, 4: text.push_back(eapf_pkg::BACKSLASH);
				5, 6: text.push_back(shadow_pattern[8 * $urandom_range(0, elen - 1) +: 8]);
				default: text.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		for (i = 0; i < text.size(); i++)
			push_byte(text[i], i == text.size() - 1);
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == eapf_pkg::CFG_PATTERN_BYTES)
			shadow_pattern = value;
		else
			shadow_length = value[3:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every byte is taken and every result is back. The check
	// waits past the falling edge so that the sender's updates have settled.
	task automatic wait_idle();
		do begin
			@(negedge clk);
			#1;
		end while (text_queue.size() != 0 || s_tvalid || results_due.size() != 0);
	endtask

	// Stimulus: reset, directed texts, then random phases.
	initial begin
		int          phase;
		logic [3:0]  new_len;
		logic [63:0] new_pattern;
		int          i;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset pattern is one zero byte; an escaped zero must not match.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(eapf_pkg::BACKSLASH, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(eapf_pkg::BACKSLASH, 1'b0);
		push_byte(eapf_pkg::BACKSLASH, 1'b0);
		push_byte(8'h00, 1'b1);
		wait_idle();

		// Overlapping candidates, an escaped candidate and a short text.
		write_reg(eapf_pkg::CFG_PATTERN_BYTES, 64'h61_62_61);
		write_reg(eapf_pkg::CFG_PATTERN_LENGTH, 64'd3);
		queue_text("ababa\\aba");
		queue_text("ab");
		wait_idle();

		// A zero length never matches.
		write_reg(eapf_pkg::CFG_PATTERN_LENGTH, 64'd0);
		queue_text("aaa");
		wait_idle();

		// An oversized length is clipped to the full window.
		write_reg(eapf_pkg::CFG_PATTERN_BYTES, '1);
		write_reg(eapf_pkg::CFG_PATTERN_LENGTH, 64'd15);
		for (i = 0; i < 9; i++)
			push_byte(8'hFF, i == 8);
		wait_idle();

		for (phase = 0; phase < 12; phase++) begin
			case (phase)
				0: new_len = 4'd8;
				1: new_len = 4'd1;
				6: new_len = 4'($urandom_range(2, 4));
				default: begin
					case ($urandom_range(0, 9))
						0: new_len = 4'd0;
						1: new_len = 4'($urandom_range(9, 15));
						2: new_len = 4'd8;
						default: new_len = 4'($urandom_range(1, 5));
					endcase
				end
			endcase
			if ($urandom_range(0, 2) == 0) begin
				new_pattern = {$urandom, $urandom};
			end else begin
				for (i = 0; i < 8; i++) begin
					case ($urandom_range(0, 3))
						0: new_pattern[8 * i +: 8] = 8'h61;
						1: new_pattern[8 * i +: 8] = 8'h62;
						2: new_pattern[8 * i +: 8] = eapf_pkg::BACKSLASH;
						default: new_pattern[8 * i +: 8] = 8'h00;
					endcase
				end
			end
			write_reg(eapf_pkg::CFG_PATTERN_BYTES, new_pattern);
			write_reg(eapf_pkg::CFG_PATTERN_LENGTH, {60'd0, new_len});

			phase_items = 0;
			while (phase_items < 30)
				queue_random_text(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24));
			// Hold off the result side while bytes keep coming.
			if (phase % 4 == 1)
				hold_requests++;
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** escape_aware_pattern_finder: PASSED **");
		else
			$display("** escape_aware_pattern_finder: FAILED **");
		$finish;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (text_queue.size() != 0) begin
				next_item = text_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_item.text_byte;
				s_tlast <= next_item.last_byte;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random ready at a rate redrawn from four settings, with long holds on request.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_count == 0) begin
				rx_count = 48;
				case ($urandom_range(0, 3))
					0: ready_pct = 100;
					1: ready_pct = 80;
					2: ready_pct = 50;
					default: ready_pct = 20;
				endcase
			end
			rx_count--;
			m_tready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	// Each accepted byte owes one result.
	always @(posedge clk) begin
		eapf_pkg::result_t r;
		in_taken <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			scan_byte(s_tdata, s_tlast, r);
			results_due.push_back(r);
		end
	end

	// Check every accepted result against the oldest one owed.
	always @(posedge clk) begin
		eapf_pkg::result_t got;
		eapf_pkg::result_t want;
		if (m_tvalid && m_tready) begin
			got.match_found = m_tuser[0];
			got.match_start = m_tdata;
			got.text_end = m_tlast;
			got.offset_overflow = m_tuser[1];
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: found=%b start=%0d end=%b ovf=%b",
						got.match_found, got.match_start, got.text_end,
						got.offset_overflow);
			end else begin
				want = results_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected found=%b start=%0d end=%b ",
							"ovf=%b, got found=%b start=%0d end=%b ovf=%b"},
							want.match_found, want.match_start, want.text_end,
							want.offset_overflow, got.match_found, got.match_start,
							got.text_end, got.offset_overflow);
				end
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** escape_aware_pattern_finder: FAILED **");
			$finish;
		end
	end

endmodule
